// File: hw/rtl/mme_pkg.sv
`timescale 1ns / 1ps

package mme_pkg;

	localparam int MAX_DIM = 16;
	localparam int FRAC_BITS = 12;

	localparam int IDX_W = 4;
	localparam int VAL_W = 16;
	localparam int CFG_W = 5;
	localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
	localparam int K_W = $clog2(MAX_DIM + 1);
	localparam int PROD_W = 2 * VAL_W - FRAC_BITS;
	localparam int ACC_W = PROD_W + $clog2(MAX_DIM) + 1;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [1:0] FUNC_LOAD_A = 2'd0;
	localparam logic [1:0] FUNC_LOAD_B = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_DIM_MISMATCH = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	localparam logic [1:0] REG_ROWS_A = 2'd0;
	localparam logic [1:0] REG_INNER_DIM = 2'd1;
	localparam logic [1:0] REG_ROWS_B = 2'd2;
	localparam logic [1:0] REG_COLS_B = 2'd3;

	typedef struct packed {
		logic [1:0] func;
		logic [IDX_W-1:0] row_index;
		logic [IDX_W-1:0] col_index;
		logic signed [VAL_W-1:0] elem_value;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] out_row;
		logic [IDX_W-1:0] out_col;
		logic signed [VAL_W-1:0] product_value;
		logic [1:0] status;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

endpackage

// File: hw/rtl/matrix_multiply_engine.sv
`timescale 1ns / 1ps

// matrix product engine, Q4.12 elements
// item channel (item_valid / item_stall / item): func selects load of an A
// element, load of a B element, or a query of one product element (row, col).
// a load gives no result; func 3 is dropped.
// a query walks the inner dimension through one shared multiply-accumulate,
// one term per cycle, reading both stores at one address each per cycle.
// a valid query feeds registered reads and a registered product into the
// accumulator; a query rejected for a dimension mismatch or a bad dimension
// or index answers with a zero value. item_stall is high while a query is
// in flight. result channel (result_valid / result_stall / result): a result
// waits in the output register while result_stall is high; loads and new
// queries are still accepted, and a finished query holds until the register
// frees. configuration via APB-style port, which the user writes only while
// idle; the block does not enforce this. pready is tied high. reset clears
// control state and sets every dimension to 16; the element stores are not
// cleared and must be loaded before they are queried.
module matrix_multiply_engine import mme_pkg::*; (
	input logic clk,
	input logic arst_n,

	input logic item_valid,
	output logic item_stall,
	input item_t item,

	output logic result_valid,
	input logic result_stall,
	output result_t result,

	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic pready
);

	logic [CFG_W-1:0] rows_a_q;
	logic [CFG_W-1:0] inner_dim_q;
	logic [CFG_W-1:0] rows_b_q;
	logic [CFG_W-1:0] cols_b_q;

	state_t state_q, state_d;

	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] col_q;
	logic [1:0] status_q;
	logic [K_W-1:0] k_q;
	logic signed [ACC_W-1:0] acc_q;

	logic rd_v_s1;
	logic signed [VAL_W-1:0] a_s1;
	logic signed [VAL_W-1:0] b_s1;
	logic mul_v_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic result_valid_q;
	result_t result_q;

	logic item_acc;
	logic query_go;
	logic rd_en;
	logic load_result;
	logic cfg_wr;
	logic [1:0] query_status;
	logic [ADDR_W-1:0] a_addr;
	logic [ADDR_W-1:0] b_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic wr_in_range;
	logic signed [2*VAL_W-1:0] prod_full;
	logic signed [VAL_W-1:0] sat_value;

	logic signed [VAL_W-1:0] left_mem [MAX_DIM*MAX_DIM];
	logic signed [VAL_W-1:0] right_mem [MAX_DIM*MAX_DIM];

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= CFG_W'(MAX_DIM);
			inner_dim_q <= CFG_W'(MAX_DIM);
			rows_b_q <= CFG_W'(MAX_DIM);
			cols_b_q <= CFG_W'(MAX_DIM);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_ROWS_A: rows_a_q <= pwdata[CFG_W-1:0];
				REG_INNER_DIM: inner_dim_q <= pwdata[CFG_W-1:0];
				REG_ROWS_B: rows_b_q <= pwdata[CFG_W-1:0];
				REG_COLS_B: cols_b_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ROWS_A: prdata = PDATA_W'(rows_a_q);
			REG_INNER_DIM: prdata = PDATA_W'(inner_dim_q);
			REG_ROWS_B: prdata = PDATA_W'(rows_b_q);
			REG_COLS_B: prdata = PDATA_W'(cols_b_q);
			default: prdata = '0;
		endcase
	end

	// query checks, mismatch first
	always_comb begin
		if (inner_dim_q != rows_b_q) begin
			query_status = STATUS_DIM_MISMATCH;
		end else if (rows_a_q == '0 || rows_a_q > CFG_W'(MAX_DIM) ||
				inner_dim_q == '0 || inner_dim_q > CFG_W'(MAX_DIM) ||
				cols_b_q == '0 || cols_b_q > CFG_W'(MAX_DIM) ||
				CFG_W'(item.row_index) >= rows_a_q ||
				CFG_W'(item.col_index) >= cols_b_q) begin
			query_status = STATUS_RANGE;
		end else begin
			query_status = STATUS_OK;
		end
	end

	assign item_acc = item_valid && !item_stall;
	assign query_go = item_acc && (item.func == FUNC_QUERY);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		item_stall = 1'b1;
		rd_en = 1'b0;
		load_result = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (query_go) begin
					state_d = (query_status == STATUS_OK) ? ST_RUN : ST_DONE;
				end
			end
			ST_RUN: begin
				rd_en = (k_q != inner_dim_q);
				if (k_q == inner_dim_q && !rd_v_s1 && !mul_v_s2) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!result_valid_q || !result_stall) begin
					load_result = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (query_go) begin
			row_q <= item.row_index;
			col_q <= item.col_index;
			status_q <= query_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			rd_v_s1 <= 1'b0;
			mul_v_s2 <= 1'b0;
			acc_q <= '0;
		end else begin
			rd_v_s1 <= rd_en;
			mul_v_s2 <= rd_v_s1;
			if (query_go) begin
				k_q <= '0;
				acc_q <= '0;
			end else begin
				if (rd_en) begin
					k_q <= k_q + K_W'(1);
				end
				if (mul_v_s2) begin
					acc_q <= acc_q + ACC_W'(prod_s2);
				end
			end
		end
	end

	// element stores
	assign wr_in_range = (int'(item.row_index) < MAX_DIM) && (int'(item.col_index) < MAX_DIM);
	assign wr_addr = ADDR_W'(ADDR_W'(item.row_index) * ADDR_W'(MAX_DIM) +
		ADDR_W'(item.col_index));
	assign a_addr = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(MAX_DIM) + ADDR_W'(k_q));
	assign b_addr = ADDR_W'(ADDR_W'(k_q) * ADDR_W'(MAX_DIM) + ADDR_W'(col_q));

	always_ff @(posedge clk) begin
		if (item_acc && item.func == FUNC_LOAD_A && wr_in_range) begin
			left_mem[wr_addr] <= item.elem_value;
		end
		a_s1 <= left_mem[a_addr];
	end

	always_ff @(posedge clk) begin
		if (item_acc && item.func == FUNC_LOAD_B && wr_in_range) begin
			right_mem[wr_addr] <= item.elem_value;
		end
		b_s1 <= right_mem[b_addr];
	end

	// shared multiplier, product floored by the fraction width
	assign prod_full = a_s1 * b_s1;

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(prod_full >>> FRAC_BITS);
	end

	always_comb begin
		if (acc_q > ACC_W'(32767)) begin
			sat_value = 16'sh7fff;
		end else if (acc_q < -ACC_W'(32768)) begin
			sat_value = -16'sh8000;
		end else begin
			sat_value = VAL_W'(acc_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_result) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			result_q.out_row <= row_q;
			result_q.out_col <= col_q;
			result_q.status <= status_q;
			result_q.product_value <= (status_q == STATUS_OK) ? sat_value : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule
